>>> rtl/core/cfir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfir_pkg
// shared types and constants of the complex fir filter
// ----------------------------------------------------------------------------
package cfir_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int TAP_CNT_W   = 7;
  localparam int TAP_IDX_W   = 6;
  localparam int ROUND_SHIFT = COEF_W - 1;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample_i;
    logic signed [SAMPLE_W-1:0] sample_q;
    logic [TAP_IDX_W-1:0]       tap_index;
    logic signed [COEF_W-1:0]   tap_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_i;
    logic signed [SAMPLE_W-1:0] out_q;
    logic                       clipped;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] i;
    logic signed [SAMPLE_W-1:0] q;
  } sample_pair_t;

  // control of one multiply-accumulate lane
  typedef struct packed {
    logic clear;
    logic vld;
  } lane_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/cfir_mac_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfir_mac_lane
// one multiply-accumulate lane: registered product, then accumulate
// ----------------------------------------------------------------------------
module cfir_mac_lane #(
  parameter int ACC_W = 40
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire cfir_pkg::lane_ctl_t               ctl,
  input  wire logic signed [cfir_pkg::SAMPLE_W-1:0] sample,
  input  wire logic signed [cfir_pkg::COEF_W-1:0]   coef,
  output logic signed [ACC_W-1:0]                acc
);
  import cfir_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      prod <= sample * coef;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cfir_round_sat.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfir_round_sat
// merge stage: rounds both lane sums, dropping the q1.15 tap scale, saturates, flags clipping
// ----------------------------------------------------------------------------
module cfir_round_sat #(
  parameter int ACC_W = 40
) (
  input  wire logic signed [ACC_W-1:0] acc_i,
  input  wire logic signed [ACC_W-1:0] acc_q,
  output cfir_pkg::out_item_t          result
);
  import cfir_pkg::*;

  localparam logic signed [ACC_W:0] HALF = (ACC_W+1)'(1) <<< (ROUND_SHIFT - 1);
  localparam logic signed [ACC_W:0] HI   = (ACC_W+1)'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W:0] LO   = -HI - (ACC_W+1)'(1);

  logic signed [ACC_W:0] sh_i, sh_q;
  logic                  hi_i, lo_i, hi_q, lo_q;

  // arithmetic shift floors, which gives round half up
  assign sh_i = ((ACC_W+1)'(acc_i) + HALF) >>> ROUND_SHIFT;
  assign sh_q = ((ACC_W+1)'(acc_q) + HALF) >>> ROUND_SHIFT;

  assign hi_i = sh_i > HI;
  assign lo_i = sh_i < LO;
  assign hi_q = sh_q > HI;
  assign lo_q = sh_q < LO;

  always_comb begin
    result.out_i   = hi_i ? SAMPLE_W'(HI) : (lo_i ? SAMPLE_W'(LO) : SAMPLE_W'(sh_i));
    result.out_q   = hi_q ? SAMPLE_W'(HI) : (lo_q ? SAMPLE_W'(LO) : SAMPLE_W'(sh_q));
    result.clipped = hi_i | lo_i | hi_q | lo_q;
  end

endmodule

`default_nettype wire

>>> rtl/core/complex_fir_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_fir_filter
// direct-form fir on i/q samples with real q1.15 taps, one mac lane per
// component over a circular delay memory, merged by a round/saturate stage
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------
//  in       | in_valid / in_stall        | in_data  (cfir_pkg::in_item_t)
//  out      | out_valid / out_stall      | out_data (cfir_pkg::out_item_t)
//  cfg      | cfg_write_en               | cfg_write_data (tap_count)
//
//  a filter transfer with n taps in use occupies the block as follows:
//  one tap per cycle through the delay and coefficient memory read ports,
//  then the read/multiply/accumulate drain and a push state that waits
//  for the output; pass through goes straight to push, a load stays idle.
//  the output register holds a result under out_stall while the next item
//  is accepted; rst clears control state, a tap_count write empties the
//  delay line at once through the fill count.
// ----------------------------------------------------------------------------
module complex_fir_filter #(
  parameter int MAX_TAPS = 64
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire cfir_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output cfir_pkg::out_item_t              out_data,
  input  wire                              cfg_write_en,
  input  wire [cfir_pkg::TAP_CNT_W-1:0]    cfg_write_data
);
  import cfir_pkg::*;

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int EXT_W = ((CW > TAP_CNT_W) ? CW : TAP_CNT_W) + 1;
  localparam int IX_W  = ((AW > TAP_IDX_W) ? AW : TAP_IDX_W) + 1;
  localparam int ACC_W = PROD_W + CW + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_PUSH  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [TAP_CNT_W-1:0] tap_count;
  logic [CW-1:0]        n_taps;
  logic [CW-1:0]        fill;
  logic [CW-1:0]        tap_cnt;
  logic [AW-1:0]        head;
  logic [AW-1:0]        head_dec;
  logic [AW-1:0]        rd_ptr;

  sample_pair_t         dly_mem [MAX_TAPS];
  logic signed [COEF_W-1:0] coef_mem [MAX_TAPS];

  sample_pair_t         dly_rd;
  logic signed [COEF_W-1:0] coef_rd;
  logic                 rd_vld;
  logic                 rd_live;
  logic                 mul_vld;

  out_item_t            res;
  out_item_t            merged;
  logic signed [ACC_W-1:0] acc_i, acc_q;
  lane_ctl_t            lane_ctl;

  logic                 accept;
  logic                 do_filter;
  logic                 do_pass;
  logic                 do_load;
  logic                 push_ok;
  logic                 last_tap;
  logic [EXT_W-1:0]     tc_ext;
  logic [IX_W-1:0]      ld_idx;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // taps above the delay depth act as the full depth
  assign tc_ext = EXT_W'(tap_count);
  assign n_taps = (tc_ext > EXT_W'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(tap_count);

  assign do_load   = accept && (in_data.op == OP_LOAD);
  assign do_pass   = accept && (in_data.op == OP_FILTER) && (n_taps == '0);
  assign do_filter = accept && (in_data.op == OP_FILTER) && (n_taps != '0);

  assign ld_idx   = IX_W'(in_data.tap_index);
  assign head_dec = (head == '0) ? AW'(MAX_TAPS - 1) : head - 1'b1;
  assign last_tap = (tap_cnt == n_taps - 1'b1);
  assign push_ok  = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (do_filter) begin
          state_next = S_RUN;
        end else if (do_pass) begin
          state_next = S_PUSH;
        end
      end
      S_RUN: begin
        if (last_tap) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld && !mul_vld) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push_ok) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_count <= '0;
      head      <= '0;
      fill      <= '0;
      tap_cnt   <= '0;
      rd_vld    <= 1'b0;
      mul_vld   <= 1'b0;
    end else begin
      state   <= state_next;
      rd_vld  <= (state == S_RUN);
      mul_vld <= rd_vld;
      if (cfg_write_en) begin
        tap_count <= cfg_write_data;
        head      <= '0;
        fill      <= '0;
      end else if (do_filter) begin
        head <= head_dec;
        if (fill != CW'(MAX_TAPS)) begin
          fill <= fill + 1'b1;
        end
      end
      if (do_filter) begin
        tap_cnt <= '0;
      end else if (state == S_RUN) begin
        tap_cnt <= tap_cnt + 1'b1;
      end
    end
  end

  // read pointer walks from the newest sample toward older ones
  always_ff @(posedge clk) begin
    if (do_filter) begin
      rd_ptr <= head_dec;
    end else if (state == S_RUN) begin
      rd_ptr <= (rd_ptr == AW'(MAX_TAPS - 1)) ? '0 : rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_filter) begin
      dly_mem[head_dec] <= '{i: in_data.sample_i, q: in_data.sample_q};
    end
    dly_rd <= dly_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_load && (ld_idx < IX_W'(MAX_TAPS))) begin
      coef_mem[ld_idx[AW-1:0]] <= in_data.tap_value;
    end
    coef_rd <= coef_mem[tap_cnt[AW-1:0]];
  end

  // entries past the fill count are masked and read as zero
  always_ff @(posedge clk) begin
    rd_live <= (tap_cnt < fill);
  end

  assign lane_ctl.clear = do_filter;
  assign lane_ctl.vld   = rd_vld;

  cfir_mac_lane #(
    .ACC_W (ACC_W)
  ) u_lane_i (
    .clk    (clk),
    .rst    (rst),
    .ctl    (lane_ctl),
    .sample (rd_live ? dly_rd.i : '0),
    .coef   (coef_rd),
    .acc    (acc_i)
  );

  cfir_mac_lane #(
    .ACC_W (ACC_W)
  ) u_lane_q (
    .clk    (clk),
    .rst    (rst),
    .ctl    (lane_ctl),
    .sample (rd_live ? dly_rd.q : '0),
    .coef   (coef_rd),
    .acc    (acc_q)
  );

  cfir_round_sat #(
    .ACC_W (ACC_W)
  ) u_merge (
    .acc_i  (acc_i),
    .acc_q  (acc_q),
    .result (merged)
  );

  always_ff @(posedge clk) begin
    if (do_pass) begin
      res <= '{out_i: in_data.sample_i, out_q: in_data.sample_q, clipped: 1'b0};
    end else if ((state == S_DRAIN) && !rd_vld && !mul_vld) begin
      res <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_PUSH) && push_ok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_PUSH) && push_ok) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire
